// ===== rtl/kca_pkg.sv =====
// constants and key mask table for the key click auto-repeat block
package kca_pkg;

  localparam int KEY_BITS      = 13;
  localparam int TABLE_ENTRIES = 14;
  localparam int INDEX_BITS    = 4;
  localparam int TICK_BITS     = 32;
  localparam int DELAY_BITS    = 16;
  localparam int CFG_IDX_BITS  = 2;

  localparam logic [CFG_IDX_BITS-1:0] CFG_INITIAL_DELAY = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_REPEAT_DELAY  = 2'd1;

  localparam logic [DELAY_BITS-1:0] INITIAL_DELAY_RESET = 16'd300;
  localparam logic [DELAY_BITS-1:0] REPEAT_DELAY_RESET  = 16'd40;

  typedef logic [KEY_BITS-1:0]   key_word_t;
  typedef logic [INDEX_BITS-1:0] key_index_t;
  typedef logic [TICK_BITS-1:0]  tick_t;
  typedef logic [DELAY_BITS-1:0] delay_t;

  // priority order, entry i reports as index i+1
  localparam logic [31:0] KEY_TABLE [TABLE_ENTRIES] = '{
    32'h0000_0001, 32'h0000_0002, 32'h0000_0008, 32'h0000_0004,
    32'h0000_0100, 32'h0000_0030, 32'h0000_0020, 32'h0000_0010,
    32'h0000_0040, 32'h0000_0080, 32'h0000_0200, 32'h0000_0400,
    32'h0000_1000, 32'h0000_1000
  };

  function automatic key_word_t entry_mask(input int idx);
    entry_mask = KEY_TABLE[idx][KEY_BITS-1:0];
  endfunction

endpackage

// ===== rtl/key_click_autorepeat.sv =====
// key click detector with typematic auto-repeat, top level
//
// input channel: in_valid / in_stall carry key_word (active low lines),
// tick_ms and clear_repeat; a transaction completes when in_valid is high
// and in_stall is low. output channel: out_valid / out_stall carry
// auto_key, clicked_key and pressed_key, one result per input transaction.
// configuration: cfg_valid / cfg_ready with cfg_index and cfg_data;
// index 0 is initial_delay, index 1 is repeat_delay, others are ignored.
// cfg_ready is always high; write only while the block is idle.
// the result of an input transaction passes an input register, then the
// table scan, tick compare and state update in front of the result
// register, and out_valid rises when it is loaded there. one transaction
// per cycle sustained while out_stall is low.
// when out_stall is held the result register keeps its value, the input
// register fills and then in_stall rises until the result is taken.
// reset clears both stages, sets the key history to nothing pressed,
// forgets the repeat key and loads the delay registers with 300 and 40.
module key_click_autorepeat (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  kca_pkg::key_word_t         key_word,
  input  kca_pkg::tick_t             tick_ms,
  input  logic                       clear_repeat,
  output logic                       out_valid,
  input  logic                       out_stall,
  output kca_pkg::key_index_t        auto_key,
  output kca_pkg::key_index_t        clicked_key,
  output kca_pkg::key_index_t        pressed_key,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [kca_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  kca_pkg::delay_t            cfg_data
);
  import kca_pkg::*;

  delay_t     initial_delay;
  delay_t     repeat_delay;

  logic       s1_valid;
  key_word_t  s1_keys;
  tick_t      s1_tick;
  logic       s1_clear;

  key_word_t  last_keys;
  key_index_t repeat_key;
  tick_t      repeat_time;
  logic       repeating;

  logic       out_free;
  logic       advance;

  logic [(1<<INDEX_BITS)-1:0] held;
  logic [(1<<INDEX_BITS)-1:0] click;
  key_index_t clicked_next;
  key_index_t pressed_next;
  key_index_t auto_next;
  key_index_t repeat_key_next;
  tick_t      repeat_time_next;
  logic       repeating_next;
  key_index_t rk;
  tick_t      elapsed;
  tick_t      limit;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;
  assign advance   = s1_valid && out_free;
  assign in_stall  = s1_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      initial_delay <= INITIAL_DELAY_RESET;
      repeat_delay  <= REPEAT_DELAY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_INITIAL_DELAY: initial_delay <= cfg_data;
        CFG_REPEAT_DELAY:  repeat_delay  <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
    if (in_valid && !in_stall) begin
      s1_keys  <= key_word;
      s1_tick  <= tick_ms;
      s1_clear <= clear_repeat;
    end
  end

  // table scan
  always_comb begin
    held = '0;
    click = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      held[i+1]  = (entry_mask(i) != '0) && ((s1_keys & entry_mask(i)) == '0);
      click[i+1] = held[i+1] && ((last_keys & entry_mask(i)) != '0);
    end
    clicked_next = '0;
    pressed_next = '0;
    for (int i = TABLE_ENTRIES; i >= 1; i--) begin
      if (click[i]) clicked_next = INDEX_BITS'(i);
      if (held[i])  pressed_next = INDEX_BITS'(i);
    end
  end

  // auto-repeat
  always_comb begin
    rk               = s1_clear ? '0 : repeat_key;
    elapsed          = s1_tick - repeat_time;
    limit            = repeating ? TICK_BITS'(repeat_delay) : TICK_BITS'(initial_delay);
    auto_next        = '0;
    repeat_key_next  = rk;
    repeat_time_next = repeat_time;
    repeating_next   = repeating;
    if (clicked_next != '0) begin
      repeat_key_next  = clicked_next;
      repeating_next   = 1'b0;
      repeat_time_next = s1_tick;
      auto_next        = clicked_next;
    end else if (rk != '0 && held[rk]) begin
      if (elapsed > limit) begin
        repeating_next   = 1'b1;
        repeat_time_next = s1_tick;
        auto_next        = rk;
      end
    end else begin
      repeat_key_next = '0;
    end
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      last_keys   <= '1;
      repeat_key  <= '0;
      repeat_time <= '0;
      repeating   <= 1'b0;
    end else begin
      if (advance) begin
        out_valid   <= 1'b1;
        last_keys   <= s1_keys;
        repeat_key  <= repeat_key_next;
        repeat_time <= repeat_time_next;
        repeating   <= repeating_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
    if (advance) begin
      auto_key    <= auto_next;
      clicked_key <= clicked_next;
      pressed_key <= pressed_next;
    end
  end

  a_click_is_pressed: assert property (@(posedge clk) disable iff (rst)
    out_valid && clicked_key != '0 |-> pressed_key != '0 && pressed_key <= clicked_key)
    else $error("clicked key without an earlier pressed key");

  a_click_drives_auto: assert property (@(posedge clk) disable iff (rst)
    out_valid && clicked_key != '0 |-> auto_key == clicked_key)
    else $error("auto key differs from click");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(auto_key) && $stable(pressed_key))
    else $error("stalled result changed");

  a_stall_needs_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid)
    else $error("input stalled with room in the pipeline");

endmodule
